@@ rtl/stable_priority_queue_defines.svh @@
// ---------------------------------------------------------------------------
// stable_priority_queue_defines.svh
// Assertion macros shared by the priority queue RTL.
// ---------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset
`define SPQ_ASSERT_NOW(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset
`define SPQ_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error(msg);

`endif

@@ rtl/spq_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spq_pkg
// Types and constants for the sorted-cell priority queue.
// ---------------------------------------------------------------------------
package spq_pkg;

   // Number of cells in the chain
   localparam int CAPACITY = 16;
   // Count register holds 0..CAPACITY
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Fixed field widths
   localparam int REQ_W    = 2;
   localparam int DATA_W   = 16;
   localparam int ENTRY_W  = 5;

   // Request codes
   localparam logic [REQ_W-1:0] REQ_ENQ  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_DEQ  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_PEEK = 2'd2;

   // Operation broadcast to every cell
   typedef enum logic [1:0] {
      OP_HOLD = 2'd0,
      OP_INS  = 2'd1,
      OP_POP  = 2'd2
   } op_type;

   // One stored entry
   typedef struct packed {
      logic [DATA_W-1:0] prio;
      logic [DATA_W-1:0] hndl;
   } slot_type;

   // Control word broadcast to the chain
   typedef struct packed {
      op_type   op;
      slot_type new_slot;
   } cell_ctrl_type;

endpackage

@@ rtl/spq_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spq_req_if / spq_rsp_if
// Valid/ready channels for queue requests and results.
// ---------------------------------------------------------------------------
interface spq_req_if;
   import spq_pkg::*;

   logic              valid;
   logic              ready;
   logic [REQ_W-1:0]  req_type;
   logic [DATA_W-1:0] item_handle;
   logic [DATA_W-1:0] item_priority;

   modport source (output valid, output req_type, output item_handle,
                   output item_priority, input ready);
   modport sink   (input valid, input req_type, input item_handle,
                   input item_priority, output ready);
endinterface

interface spq_rsp_if;
   import spq_pkg::*;

   logic               valid;
   logic               ready;
   logic [DATA_W-1:0]  out_handle;
   logic               out_valid;
   logic               overflow;
   logic [DATA_W-1:0]  head_priority;
   logic [ENTRY_W-1:0] entry_count;
   logic               is_empty;

   modport source (output valid, output out_handle, output out_valid,
                   output overflow, output head_priority, output entry_count,
                   output is_empty, input ready);
   modport sink   (input valid, input out_handle, input out_valid,
                   input overflow, input head_priority, input entry_count,
                   input is_empty, output ready);
endinterface

@@ rtl/spq_cell.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: compares, then holds, inserts, or shifts each cycle.
// ---------------------------------------------------------------------------
module spq_cell (
   input  logic                   clock,
   input  spq_pkg::cell_ctrl_type ctrl,
   input  logic                   occupied,
   input  logic                   gt_left,
   input  spq_pkg::slot_type      slot_left,
   input  spq_pkg::slot_type      slot_right,
   output logic                   gt_out,
   output spq_pkg::slot_type      slot_out,
   output spq_pkg::slot_type      slot_next
);
   import spq_pkg::*;

   slot_type slot_ff;
   slot_type slot_in;

   // Insertion point: an empty cell or one whose priority is strictly larger
   assign gt_out = !occupied || (slot_ff.prio > ctrl.new_slot.prio);

   // Next slot content
   always_comb begin
      slot_in = slot_ff;
      case (ctrl.op)
         OP_INS: begin
            if (gt_out) begin
               slot_in = gt_left ? slot_left : ctrl.new_slot;
            end
         end
         OP_POP:  slot_in = slot_right;
         OP_HOLD: slot_in = slot_ff;
         default: slot_in = slot_ff;
      endcase
   end

   // Payload register, no reset needed
   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign slot_out  = slot_ff;
   assign slot_next = slot_in;

endmodule

@@ rtl/stable_priority_queue.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stable_priority_queue
// Bounded stable priority queue built as a chain of sorted cells.
// ---------------------------------------------------------------------------
//  Port       Dir  Words
//  req_chan   in   request: req_type, item_handle, item_priority
//  rsp_chan   out  result: handle, valid, overflow, head, count, empty
//
//  For each request word every cell compares in parallel and shifts toward
//  its neighbor in the same edge, so one word per clock while results drain.
//  Results sit in one output register; a new request is taken whenever
//  that register is empty or is being drained in the same cycle.
//  Reset (sync, active high) empties queue and result stage, holds ready low.
//  A stalled result holds the chain still until it is taken.
// ---------------------------------------------------------------------------
`include "stable_priority_queue_defines.svh"

module stable_priority_queue (
   input  logic       clock,
   input  logic       reset,
   spq_req_if.sink    req_chan,
   spq_rsp_if.source  rsp_chan
);
   import spq_pkg::*;

   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic                 rsp_valid_ff;
   logic [DATA_W-1:0]    out_handle_ff;
   logic                 out_valid_ff;
   logic                 overflow_ff;
   logic [DATA_W-1:0]    head_ff;
   logic [CNT_W-1:0]     rsp_count_ff;

   logic                 accept;
   logic                 is_enq;
   logic                 is_deq;
   logic                 full;
   logic                 nonempty;
   cell_ctrl_type        ctrl;

   logic     [CAPACITY-1:0] occ;
   logic     [CAPACITY-1:0] gt;
   slot_type                slot_cur  [CAPACITY];
   slot_type                slot_nxt  [CAPACITY];

   // Handshake: take a word when the result register is free or draining
   assign req_chan.ready = !reset && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;

   assign full     = (count_ff == CNT_W'(CAPACITY));
   assign nonempty = (count_ff != '0);
   assign is_enq   = accept && (req_chan.req_type == REQ_ENQ);
   assign is_deq   = accept && (req_chan.req_type == REQ_DEQ);

   // Broadcast control to the chain
   always_comb begin
      ctrl.op            = OP_HOLD;
      ctrl.new_slot.prio = req_chan.item_priority;
      ctrl.new_slot.hndl = req_chan.item_handle;
      if (is_enq && !full) begin
         ctrl.op = OP_INS;
      end else if (is_deq && nonempty) begin
         ctrl.op = OP_POP;
      end
   end

   // Entry count update
   always_comb begin
      count_in = count_ff;
      case (ctrl.op)
         OP_INS:  count_in = count_ff + CNT_W'(1);
         OP_POP:  count_in = count_ff - CNT_W'(1);
         OP_HOLD: count_in = count_ff;
         default: count_in = count_ff;
      endcase
   end

   // Cell chain
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      slot_type left_slot;
      slot_type right_slot;
      logic     left_gt;

      assign occ[i] = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_first
         assign left_gt   = 1'b0;
         assign left_slot = ctrl.new_slot;
      end else begin : g_mid
         assign left_gt   = gt[i-1];
         assign left_slot = slot_cur[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_slot = '0;
      end else begin : g_inner
         assign right_slot = slot_cur[i+1];
      end

      spq_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occupied   (occ[i]),
         .gt_left    (left_gt),
         .slot_left  (left_slot),
         .slot_right (right_slot),
         .gt_out     (gt[i]),
         .slot_out   (slot_cur[i]),
         .slot_next  (slot_nxt[i])
      );
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result word register
   always_ff @(posedge clock) begin
      if (accept) begin
         out_handle_ff <= (ctrl.op == OP_POP) ? slot_cur[0].hndl : '0;
         out_valid_ff  <= (ctrl.op == OP_POP);
         overflow_ff   <= is_enq && full;
         head_ff       <= (count_in != '0) ? slot_nxt[0].prio : '0;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.out_handle    = out_handle_ff;
   assign rsp_chan.out_valid     = out_valid_ff;
   assign rsp_chan.overflow      = overflow_ff;
   assign rsp_chan.head_priority = head_ff;
   assign rsp_chan.entry_count   = ENTRY_W'(rsp_count_ff);
   assign rsp_chan.is_empty      = (rsp_count_ff == '0);

   // Checks
   `SPQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1,
      count_ff <= CNT_W'(CAPACITY), "count above capacity")
   `SPQ_ASSERT_NEXT(a_pop_count, clock, reset, ctrl.op == OP_POP,
      count_ff == $past(count_ff) - CNT_W'(1), "pop did not lower count")
   `SPQ_ASSERT_NOW(a_ovf_full, clock, reset, rsp_valid_ff && overflow_ff,
      rsp_count_ff == CNT_W'(CAPACITY), "overflow while not full")
   `SPQ_ASSERT_NOW(a_pop_excl, clock, reset, rsp_valid_ff && out_valid_ff,
      !overflow_ff && (rsp_count_ff != CNT_W'(CAPACITY)), "pop result inconsistent")

endmodule

@@ dv/tb_stable_priority_queue.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_stable_priority_queue
// Self-checking bench for the bounded stable priority queue.
// ---------------------------------------------------------------------------
//  A short table of directed request words opens the run: empty-queue
//  dequeue and peek, the unused request code, priority and handle extremes,
//  equal priorities (FIFO order), filling to capacity and enqueue overflow.
//  Obvious rows carry their result inline, the rest go through a sorted-list
//  model of the queue kept here. Random fill/drain/mixed phases follow, with
//  bursty stalls on both channels, then a quiet tail with no stalls.
// ---------------------------------------------------------------------------
module tb_stable_priority_queue;
   import spq_pkg::*;

   localparam logic [REQ_W-1:0] REQ_RSVD = 2'd3;   // unused code, acts as peek
   localparam int RANDOM_WORDS = 725;
   localparam int QUIET_WORDS  = 100;

   // Result word as seen on the rsp channel
   typedef struct packed {
      logic [DATA_W-1:0]  hndl;
      logic               hit;
      logic               ovf;
      logic [DATA_W-1:0]  head;
      logic [ENTRY_W-1:0] count;
      logic               empty;
   } status_type;

   typedef struct {
      logic [REQ_W-1:0]  kind;
      logic [DATA_W-1:0] hndl;
      logic [DATA_W-1:0] prio;
      bit                typed;
      status_type        want;
   } drill_row_type;

   logic clock;
   logic reset;

   spq_req_if req_if ();
   spq_rsp_if rsp_if ();

   stable_priority_queue DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // Side band that travels with each request word
   bit         drv_typed;
   status_type drv_want;

   // Queue model and scoreboard
   slot_type      sorted_slots [CAPACITY];
   int            held_entries;
   status_type    pending_status [$];
   drill_row_type drill_q [$];

   int idle_pct;
   int error_count;
   int results_checked;
   int inserts, overflows, pops, empty_pops, peeks;

   // Clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Overall time limit
   initial begin
      #2_000_000;
      $display("%0t: run timed out, %0d results outstanding", $realtime,
               pending_status.size());
      $display("== FAIL ==");
      $finish;
   end

   // Apply one request to the model, return the status it yields
   function automatic status_type queue_step_status(logic [REQ_W-1:0] kind,
                                                    logic [DATA_W-1:0] hndl,
                                                    logic [DATA_W-1:0] prio);
      status_type st;
      int i;
      st = '0;
      if (kind == REQ_ENQ) begin
         if (held_entries >= CAPACITY) begin
            st.ovf = 1'b1;
         end else begin
            // shift up every entry with a strictly larger priority
            for (i = held_entries; i > 0 && sorted_slots[i-1].prio > prio; i--)
               sorted_slots[i] = sorted_slots[i-1];
            sorted_slots[i].prio = prio;
            sorted_slots[i].hndl = hndl;
            held_entries++;
         end
      end else if (kind == REQ_DEQ) begin
         if (held_entries > 0) begin
            st.hndl = sorted_slots[0].hndl;
            st.hit  = 1'b1;
            for (i = 1; i < held_entries; i++)
               sorted_slots[i-1] = sorted_slots[i];
            held_entries--;
         end
      end
      // peek and the unused code leave the queue alone
      st.head  = (held_entries > 0) ? sorted_slots[0].prio : '0;
      st.count = held_entries[ENTRY_W-1:0];
      st.empty = (held_entries == 0);
      return st;
   endfunction

   function automatic status_type make_status(logic [DATA_W-1:0] hndl, logic hit,
                                              logic ovf, logic [DATA_W-1:0] head,
                                              logic [ENTRY_W-1:0] count,
                                              logic empty);
      status_type st;
      st.hndl  = hndl;
      st.hit   = hit;
      st.ovf   = ovf;
      st.head  = head;
      st.count = count;
      st.empty = empty;
      return st;
   endfunction

   task automatic add_row(logic [REQ_W-1:0] kind, logic [DATA_W-1:0] hndl,
                          logic [DATA_W-1:0] prio, bit typed, status_type want);
      drill_row_type r;
      r.kind  = kind;
      r.hndl  = hndl;
      r.prio  = prio;
      r.typed = typed;
      r.want  = want;
      drill_q.push_back(r);
   endtask

   task automatic compare_field(string label, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, label,
                  want, got);
         error_count++;
      end
   endtask

   // Present one request word and hold it until it is taken
   task automatic send_word(logic [REQ_W-1:0] kind, logic [DATA_W-1:0] hndl,
                            logic [DATA_W-1:0] prio, bit typed, status_type want);
      if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.req_type      <= kind;
      req_if.item_handle   <= hndl;
      req_if.item_priority <= prio;
      drv_typed            <= typed;
      drv_want             <= want;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // Result side: bursty stalls
   initial begin
      int stall_left;
      stall_left    = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left != 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct / 2) begin
            rsp_if.ready <= 1'b0;
            stall_left = $urandom_range(2, 0);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Scoreboard: retire results first, then log newly accepted words
   always @(posedge clock) begin
      status_type want;
      status_type pred;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_status.size() == 0) begin
               $display("%0t: unexpected result word, expected none, got %0h/%0h",
                        $realtime, rsp_if.out_handle, rsp_if.entry_count);
               error_count++;
            end else begin
               want = pending_status.pop_front();
               compare_field("out_handle", want.hndl, rsp_if.out_handle);
               compare_field("out_valid", want.hit, rsp_if.out_valid);
               compare_field("overflow", want.ovf, rsp_if.overflow);
               compare_field("head_priority", want.head, rsp_if.head_priority);
               compare_field("entry_count", want.count, rsp_if.entry_count);
               compare_field("is_empty", want.empty, rsp_if.is_empty);
               results_checked++;
            end
         end
         if (req_if.valid && req_if.ready) begin
            pred = queue_step_status(req_if.req_type, req_if.item_handle,
                                     req_if.item_priority);
            pending_status.push_back(drv_typed ? drv_want : pred);
            if (req_if.req_type == REQ_ENQ) begin
               if (pred.ovf) overflows++;
               else inserts++;
            end else if (req_if.req_type == REQ_DEQ) begin
               if (pred.hit) pops++;
               else empty_pops++;
            end else begin
               peeks++;
            end
         end
      end
   end

   // Stimulus
   initial begin
      int n, mode, roll;
      logic [REQ_W-1:0]  kind;
      logic [DATA_W-1:0] prio;

      held_entries    = 0;
      error_count     = 0;
      results_checked = 0;
      inserts = 0; overflows = 0; pops = 0; empty_pops = 0; peeks = 0;
      idle_pct = 0;
      reset                <= 1'b1;
      req_if.valid         <= 1'b0;
      req_if.req_type      <= REQ_PEEK;
      req_if.item_handle   <= '0;
      req_if.item_priority <= '0;
      drv_typed            <= 1'b0;
      drv_want             <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed table: empty queue, extremes, FIFO ties, fill and overflow
      add_row(REQ_DEQ,  16'h0000, 16'h0000, 1, make_status(0, 0, 0, 16'h0000, 0, 1));
      add_row(REQ_PEEK, 16'h1111, 16'h2222, 1, make_status(0, 0, 0, 16'h0000, 0, 1));
      add_row(REQ_RSVD, 16'hFFFF, 16'hFFFF, 1, make_status(0, 0, 0, 16'h0000, 0, 1));
      add_row(REQ_ENQ,  16'hFFFF, 16'hFFFF, 1, make_status(0, 0, 0, 16'hFFFF, 1, 0));
      add_row(REQ_ENQ,  16'h0000, 16'h0000, 1, make_status(0, 0, 0, 16'h0000, 2, 0));
      add_row(REQ_ENQ,  16'h0A01, 16'h1234, 0, '0);
      add_row(REQ_ENQ,  16'h0A02, 16'h1234, 0, '0);
      add_row(REQ_ENQ,  16'h0A03, 16'h1234, 0, '0);
      add_row(REQ_ENQ,  16'h5555, 16'hFFFF, 0, '0);
      add_row(REQ_ENQ,  16'hAAAA, 16'h0001, 0, '0);
      add_row(REQ_ENQ,  16'h0A04, 16'h1234, 0, '0);
      add_row(REQ_ENQ,  16'h0B01, 16'h8000, 0, '0);
      add_row(REQ_ENQ,  16'h0B02, 16'h7FFF, 0, '0);
      add_row(REQ_ENQ,  16'h0C01, 16'h0000, 0, '0);
      add_row(REQ_ENQ,  16'h0C02, 16'h0002, 0, '0);
      add_row(REQ_ENQ,  16'h0C03, 16'h1233, 0, '0);
      add_row(REQ_ENQ,  16'h0C04, 16'h1235, 0, '0);
      add_row(REQ_ENQ,  16'h0C05, 16'hFFFE, 0, '0);
      add_row(REQ_ENQ,  16'h0C06, 16'h0003, 0, '0);
      // queue is full now: drop, then look without change
      add_row(REQ_ENQ,  16'hDEAD, 16'h0000, 1, make_status(0, 0, 1, 16'h0000, 16, 0));
      add_row(REQ_PEEK, 16'h0000, 16'h0000, 1, make_status(0, 0, 0, 16'h0000, 16, 0));
      add_row(REQ_DEQ,  16'h0000, 16'h0000, 1,
              make_status(16'h0000, 1, 0, 16'h0000, 15, 0));
      add_row(REQ_DEQ,  16'h0000, 16'h0000, 0, '0);
      add_row(REQ_DEQ,  16'h0000, 16'h0000, 0, '0);
      add_row(REQ_ENQ,  16'hFFFF, 16'h0000, 0, '0);

      for (n = 0; n < drill_q.size(); n++)
         send_word(drill_q[n].kind, drill_q[n].hndl, drill_q[n].prio,
                   drill_q[n].typed, drill_q[n].want);

      // Random phases: fill, drain or mixed, with changing stall pressure
      mode = 2;
      for (n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 40 == 0)
            mode = $urandom_range(2, 0);
         if (n >= RANDOM_WORDS - QUIET_WORDS) begin
            idle_pct = 0;
         end else if (n % 60 == 0) begin
            case ($urandom_range(2, 0))
               0:       idle_pct = 0;
               1:       idle_pct = 15;
               default: idle_pct = 40;
            endcase
         end

         roll = $urandom_range(99, 0);
         if (roll < (mode == 0 ? 80 : mode == 1 ? 15 : 45))
            kind = REQ_ENQ;
         else if (roll < (mode == 2 ? 90 : 95))
            kind = REQ_DEQ;
         else
            kind = ($urandom_range(3, 0) == 0) ? REQ_RSVD : REQ_PEEK;

         // narrow range for plenty of ties, some wide, some extremes
         roll = $urandom_range(9, 0);
         if (roll < 5) begin
            prio = DATA_W'($urandom_range(7, 0));
         end else if (roll < 8) begin
            prio = DATA_W'($urandom);
         end else begin
            case ($urandom_range(3, 0))
               0:       prio = 16'h0000;
               1:       prio = 16'hFFFF;
               2:       prio = 16'h7FFF;
               default: prio = 16'h8000;
            endcase
         end
         send_word(kind, DATA_W'($urandom), prio, 1'b0, '0);
      end
      req_if.valid <= 1'b0;

      // Drain outstanding results, then let the pipeline settle
      @(posedge clock);
      while (pending_status.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Checked %0d results: %0d inserts, %0d overflows, %0d pops,",
               results_checked, inserts, overflows, pops);
      $display("  %0d empty pops, %0d peeks, %0d mismatches", empty_pops, peeks,
               error_count);
      if (error_count == 0 && pending_status.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_if.sv
rtl/spq_cell.sv
rtl/stable_priority_queue.sv
dv/tb_stable_priority_queue.sv
